### rtl/bqe_pkg.sv
// biquad cascade equalizer: shared item types, formats and microcode table
// no dependencies
`timescale 1ns / 1ps

package bqe_pkg;

  // field widths and fixed-point formats
  localparam int PCM_W      = 16;
  localparam int COEF_W     = 24;
  localparam int SIG_W      = 40;
  localparam int FRAC       = 20;
  localparam int PART_W     = FRAC + 1;
  localparam int PROD_W     = COEF_W + PART_W;
  localparam int ACC_W      = 46;
  localparam int ROUND_HALF = 1 << (FRAC - 1);
  localparam int PCM_MAX    = 32767;
  localparam int PCM_MIN    = -32768;

  localparam int COEFS_PER_BAND = 5;

  // command codes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_FILTER = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // coefficient slots within a band
  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         channel;
    logic signed [15:0] sample_in;
    logic [4:0]         band_sel;
    logic [2:0]         coef_sel;
    logic signed [23:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [2:0]         out_channel;
    logic               clipped;
  } out_item_t;

  // microcode word
  typedef enum logic [1:0] {
    BASE_ACC  = 2'd0,
    BASE_D1   = 2'd1,
    BASE_D2   = 2'd2,
    BASE_ZERO = 2'd3
  } base_t;

  typedef enum logic [1:0] {
    TERM_NONE = 2'd0,
    TERM_LO   = 2'd1,
    TERM_HI   = 2'd2
  } term_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_Y    = 2'd1,
    WR_D1   = 2'd2,
    WR_D2   = 2'd3
  } wr_t;

  typedef enum logic [1:0] {
    J_NEXT = 2'd0,
    J_BAND = 2'd1,
    J_DONE = 2'd2
  } jump_t;

  typedef struct packed {
    logic [2:0] rd_sel;   // coefficient slot to read
    logic       mul_y;    // multiplier operand: band output instead of band input
    logic       mul_hi;   // upper operand half instead of lower
    base_t      base;
    term_t      term;
    logic       sub;
    wr_t        wr;
    jump_t      jump;
  } ctl_t;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_BAND_START = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FINAL      = 4'd13;

  function automatic ctl_t ucode_word(input logic [2:0] rd_sel, input logic mul_y,
                                      input logic mul_hi, input base_t base,
                                      input term_t term, input logic sub,
                                      input wr_t wr, input jump_t jump);
    ctl_t c;
    c.rd_sel = rd_sel;
    c.mul_y  = mul_y;
    c.mul_hi = mul_hi;
    c.base   = base;
    c.term   = term;
    c.sub    = sub;
    c.wr     = wr;
    c.jump   = jump;
    return c;
  endfunction

  // one band: coefficient read into coef_q, multiply into prod, then accumulate into acc
  function automatic ctl_t bqe_ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    unique case (step)
      4'd0:  c = ucode_word(COEF_B0, 1'b0, 1'b0, BASE_ACC,  TERM_NONE, 1'b0, WR_NONE, J_NEXT);
      4'd1:  c = ucode_word(COEF_B0, 1'b0, 1'b0, BASE_ACC,  TERM_NONE, 1'b0, WR_NONE, J_NEXT);
      4'd2:  c = ucode_word(COEF_B1, 1'b0, 1'b1, BASE_D1,   TERM_LO,   1'b0, WR_NONE, J_NEXT);
      4'd3:  c = ucode_word(COEF_B1, 1'b0, 1'b0, BASE_ACC,  TERM_HI,   1'b0, WR_NONE, J_NEXT);
      4'd4:  c = ucode_word(COEF_A1, 1'b0, 1'b1, BASE_D2,   TERM_LO,   1'b0, WR_Y,    J_NEXT);
      4'd5:  c = ucode_word(COEF_A1, 1'b1, 1'b0, BASE_ACC,  TERM_HI,   1'b0, WR_NONE, J_NEXT);
      4'd6:  c = ucode_word(COEF_B2, 1'b1, 1'b1, BASE_ACC,  TERM_LO,   1'b1, WR_NONE, J_NEXT);
      4'd7:  c = ucode_word(COEF_B2, 1'b0, 1'b0, BASE_ACC,  TERM_HI,   1'b1, WR_NONE, J_NEXT);
      4'd8:  c = ucode_word(COEF_A2, 1'b0, 1'b1, BASE_ZERO, TERM_LO,   1'b0, WR_D1,   J_NEXT);
      4'd9:  c = ucode_word(COEF_A2, 1'b1, 1'b0, BASE_ACC,  TERM_HI,   1'b0, WR_NONE, J_NEXT);
      4'd10: c = ucode_word(COEF_A2, 1'b1, 1'b1, BASE_ACC,  TERM_LO,   1'b1, WR_NONE, J_NEXT);
      4'd11: c = ucode_word(COEF_A2, 1'b1, 1'b1, BASE_ACC,  TERM_HI,   1'b1, WR_NONE, J_NEXT);
      4'd12: c = ucode_word(COEF_B0, 1'b0, 1'b0, BASE_ACC,  TERM_NONE, 1'b0, WR_D2,   J_BAND);
      4'd13: c = ucode_word(COEF_B0, 1'b0, 1'b0, BASE_ACC,  TERM_NONE, 1'b0, WR_NONE, J_DONE);
      default: c = ucode_word(COEF_B0, 1'b0, 1'b0, BASE_ACC, TERM_NONE, 1'b0, WR_NONE, J_DONE);
    endcase
    return c;
  endfunction

endpackage

### rtl/bqe_datapath.sv
// biquad cascade equalizer datapath: coefficient and delay memories,
// shared multiplier, accumulator and output rounding; uses bqe_pkg
`timescale 1ns / 1ps

module bqe_datapath #(
  parameter int NUM_BANDS    = 10,
  parameter int MAX_CHANNELS = 8,
  parameter int BW           = 4,
  parameter int CW           = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bqe_pkg::ctl_t         ctl,
  input  logic                  load_en,
  input  logic                  clear_en,
  input  logic                  start,
  input  bqe_pkg::in_item_t     cmd,
  input  logic [BW-1:0]         band,
  input  logic [CW-1:0]         ch,
  output logic signed [15:0]    fin_sample,
  output logic                  fin_clip
);
  import bqe_pkg::*;

  localparam int CDEPTH = NUM_BANDS * COEFS_PER_BAND;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int DDEPTH = NUM_BANDS * MAX_CHANNELS;
  localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
  localparam int RW     = SIG_W - FRAC + 1;

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
    logic signed [SIG_W-1:0] r;
    if (&v[ACC_W-1:SIG_W-1] || ~|v[ACC_W-1:SIG_W-1]) begin
      r = v[SIG_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(SIG_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SIG_W-1){1'b1}}};
    end
    return r;
  endfunction

  // addresses
  logic [7:0]     cw_full, cr_full, d_full;
  logic [CAW-1:0] cw_addr, cr_addr;
  logic [DAW-1:0] d_addr;

  assign cw_full = 8'(cmd.band_sel) * 8'(COEFS_PER_BAND) + 8'(cmd.coef_sel);
  assign cr_full = 8'(band) * 8'(COEFS_PER_BAND) + 8'(ctl.rd_sel);
  assign d_full  = 8'(band) * 8'(MAX_CHANNELS) + 8'(ch);
  assign cw_addr = cw_full[CAW-1:0];
  assign cr_addr = cr_full[CAW-1:0];
  assign d_addr  = d_full[DAW-1:0];

  // coefficient memory
  logic signed [COEF_W-1:0] coef_mem [CDEPTH];
  logic signed [COEF_W-1:0] coef_q;

  always_ff @(posedge clk) begin
    if (load_en) begin
      coef_mem[cw_addr] <= cmd.coef_value;
    end
    coef_q <= coef_mem[cr_addr];
  end

  // delay memories, one valid bit per band and channel
  logic signed [SIG_W-1:0] d1_mem [DDEPTH];
  logic signed [SIG_W-1:0] d2_mem [DDEPTH];
  logic signed [SIG_W-1:0] d1_q, d2_q, d1_eff, d2_eff;
  logic [DDEPTH-1:0]       vld;
  logic                    vld_q;
  logic signed [ACC_W-1:0] acc;
  logic signed [SIG_W-1:0] acc_sat;

  assign acc_sat = sat_sig(acc);

  always_ff @(posedge clk) begin
    if (ctl.wr == WR_D1) begin
      d1_mem[d_addr] <= acc_sat;
    end
    if (ctl.wr == WR_D2) begin
      d2_mem[d_addr] <= acc_sat;
    end
    d1_q <= d1_mem[d_addr];
    d2_q <= d2_mem[d_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear_en) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ctl.wr == WR_D2) begin
        vld[d_addr] <= 1'b1;
      end
      vld_q <= vld[d_addr];
    end
  end

  assign d1_eff = vld_q ? d1_q : '0;
  assign d2_eff = vld_q ? d2_q : '0;

  // band input and band output
  logic signed [SIG_W-1:0] sig, y;

  always_ff @(posedge clk) begin
    if (start) begin
      sig <= {{(SIG_W-PCM_W-FRAC){cmd.sample_in[PCM_W-1]}}, cmd.sample_in, {FRAC{1'b0}}};
    end else if (ctl.wr == WR_D2) begin
      sig <= y;
    end
    if (ctl.wr == WR_Y) begin
      y <= acc_sat;
    end
  end

  // shared multiplier, one operand half per pass
  logic signed [SIG_W-1:0]  opnd;
  logic signed [PART_W-1:0] part;
  logic signed [PROD_W-1:0] prod;

  assign opnd = ctl.mul_y ? y : sig;
  assign part = ctl.mul_hi ? {opnd[SIG_W-1], opnd[SIG_W-1:FRAC]} : {1'b0, opnd[FRAC-1:0]};

  always_ff @(posedge clk) begin
    prod <= PROD_W'(coef_q) * PROD_W'(part);
  end

  // accumulator: lower pass is rounded away, upper pass is already in place
  logic signed [PROD_W-1:0] lo_biased;
  logic signed [ACC_W-1:0]  term, addend, base_v;

  assign lo_biased = prod + PROD_W'(ROUND_HALF);

  always_comb begin
    case (ctl.term)
      TERM_LO: term = ACC_W'(lo_biased >>> FRAC);
      TERM_HI: term = ACC_W'(prod);
      default: term = '0;
    endcase
    addend = ctl.sub ? -term : term;
    unique case (ctl.base)
      BASE_ACC:  base_v = acc;
      BASE_D1:   base_v = ACC_W'(d1_eff);
      BASE_D2:   base_v = ACC_W'(d2_eff);
      BASE_ZERO: base_v = '0;
      default:   base_v = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= base_v + addend;
  end

  // final rounding to whole lsbs and clamp to 16 bits
  logic signed [SIG_W:0]  fin_biased;
  logic signed [RW-1:0]   fin_r;

  assign fin_biased = (SIG_W+1)'(sig) + (SIG_W+1)'(ROUND_HALF);
  assign fin_r      = fin_biased[SIG_W:FRAC];

  always_comb begin
    if (fin_r > RW'(PCM_MAX)) begin
      fin_sample = 16'(PCM_MAX);
      fin_clip   = 1'b1;
    end else if (fin_r < RW'(PCM_MIN)) begin
      fin_sample = 16'(PCM_MIN);
      fin_clip   = 1'b1;
    end else begin
      fin_sample = fin_r[PCM_W-1:0];
      fin_clip   = 1'b0;
    end
  end

endmodule

### rtl/biquad_cascade_equalizer.sv
// biquad cascade equalizer top level: command decode, microcode sequencer
// and result register; uses bqe_pkg and bqe_datapath
// a filter item runs the band steps once per band, then the final rounding step
// no new item is taken while a sample is in flight; two 24x21 multiplier passes per product
// load and clear items are taken without making the block busy and give no result
// reset: delay state reads as zero through per-entry valid bits, coefficients undefined
`timescale 1ns / 1ps

module biquad_cascade_equalizer #(
  parameter int NUM_BANDS    = 10,
  parameter int MAX_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  bqe_pkg::in_item_t  cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output bqe_pkg::out_item_t res
);
  import bqe_pkg::*;

  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // sequencer state
  logic              busy;
  logic [STEP_W-1:0] step;
  logic [BW-1:0]     band;
  logic [CW-1:0]     ch;
  ctl_t              ctl;

  // a new item is taken only between samples; results wait in res
  logic accept;
  assign cmd_stall = busy;
  assign accept    = cmd_valid && !busy;

  // command decode, out-of-range loads and channels are dropped
  logic load_en, clear_en, start;
  assign load_en  = accept && (cmd.mode == MODE_LOAD)
                 && ({1'b0, cmd.band_sel} < 6'(NUM_BANDS))
                 && (cmd.coef_sel < 3'(COEFS_PER_BAND));
  assign clear_en = accept && (cmd.mode == MODE_CLEAR);
  assign start    = accept && (cmd.mode == MODE_FILTER)
                 && ({1'b0, cmd.channel} < 4'(MAX_CHANNELS));

  // control word from the program rom, quiet while idle
  assign ctl = busy ? bqe_ucode(step)
                    : ucode_word(COEF_B0, 1'b0, 1'b0, BASE_ACC, TERM_NONE, 1'b0,
                                 WR_NONE, J_NEXT);

  // the final step waits until the result register is free
  logic done;
  assign done = busy && (ctl.jump == J_DONE) && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= STEP_BAND_START;
      band      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && !done) begin
        res_valid <= 1'b0;
      end
      if (start) begin
        busy <= 1'b1;
        step <= STEP_BAND_START;
        band <= '0;
      end else if (busy) begin
        unique case (ctl.jump)
          J_NEXT: step <= step + 4'd1;
          J_BAND: begin
            // after the last band go round the sample off
            if (band == BW'(NUM_BANDS - 1)) begin
              step <= STEP_FINAL;
            end else begin
              band <= band + BW'(1);
              step <= STEP_BAND_START;
            end
          end
          J_DONE: begin
            if (done) begin
              busy      <= 1'b0;
              res_valid <= 1'b1;
            end
          end
          default: step <= STEP_BAND_START;
        endcase
      end
    end
  end

  // channel of the sample in flight
  always_ff @(posedge clk) begin
    if (start) begin
      ch <= cmd.channel[CW-1:0];
    end
  end

  // datapath
  logic signed [15:0] fin_sample;
  logic               fin_clip;

  bqe_datapath #(
    .NUM_BANDS    (NUM_BANDS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .BW           (BW),
    .CW           (CW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .load_en    (load_en),
    .clear_en   (clear_en),
    .start      (start),
    .cmd        (cmd),
    .band       (band),
    .ch         (ch),
    .fin_sample (fin_sample),
    .fin_clip   (fin_clip)
  );

  // result register, holds while stalled
  always_ff @(posedge clk) begin
    if (done) begin
      res.sample_out  <= fin_sample;
      res.out_channel <= 3'(ch);
      res.clipped     <= fin_clip;
    end
  end

endmodule
